>>> rtl/core/gaussian_rgb_window_filter_unit_defines.svh
`ifndef GAUSSIAN_RGB_WINDOW_FILTER_UNIT_DEFINES_SVH
`define GAUSSIAN_RGB_WINDOW_FILTER_UNIT_DEFINES_SVH

// Both macros expect signals named clock and reset in the enclosing scope.

// Same-cycle implication.
`define GWF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("filter port check failed");

// Next-cycle implication.
`define GWF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("filter port check failed");

`endif

>>> rtl/core/gwf_pkg.sv
package gwf_pkg;

   localparam int RADIUS      = 1;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;

   localparam int WIN         = 2 * RADIUS + 1;
   localparam int NUM_TAPS    = WIN * WIN;
   localparam int STORE_DEPTH = WIN * MAX_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int CH_W        = 8;
   localparam int PIX_W       = 3 * CH_W;
   localparam int DIM_W       = 11;
   localparam int W_LIM       = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
   localparam int H_LIM       = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;

   localparam int TAP_W       = 16;
   localparam int WGT_W       = 2 * TAP_W;
   localparam int PROD_W      = WGT_W + CH_W;
   localparam int WSUM_W      = WGT_W + $clog2(NUM_TAPS);
   localparam int ACC_W       = WSUM_W + CH_W;

   localparam int TIDX_W      = $clog2(WIN);
   localparam int DELTA_W     = TIDX_W + 1;
   localparam int DIST_W      = (RADIUS > 1) ? $clog2(RADIUS + 1) : 1;
   localparam int SUM_W       = ADDR_W + 3;

   localparam int FLUSH_CYCLES = 3;
   localparam int FLUSH_W      = 2;
   localparam int STEP_W       = $clog2(CH_W + 1);
   localparam int BIT_W        = $clog2(CH_W);

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int MODE_W      = 2;

   localparam logic signed [SUM_W-1:0] DEPTH_S  = SUM_W'(STORE_DEPTH);
   localparam logic signed [DIM_W+1:0] POS_ONE  = (DIM_W + 2)'(1);

   localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADJUST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VWEIGHTS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HWEIGHTS = 3'd4;

   localparam logic OP_PIXEL = 1'b0;

   localparam logic [DIM_W-1:0]      DIM_RESET    = 11'd512;
   localparam logic [CSR_DATA_W-1:0] WEIGHT_RESET = 64'd1177121711;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_CHECK,
      ST_TAPS,
      ST_FLUSH,
      ST_NORM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             issue;
      logic [TAP_W-1:0] vtap;
      logic [TAP_W-1:0] htap;
   } mac_ctl_type;

   // Row or column offset of a mirrored tap relative to the center.
   function automatic logic signed [DELTA_W-1:0] tap_delta(
      input logic [DIM_W-1:0]          pos,
      input logic signed [DELTA_W-1:0] ofs,
      input logic [DIM_W-1:0]          lim
   );
      logic signed [DIM_W+1:0] p;
      logic signed [DIM_W+1:0] oe;
      logic signed [DIM_W+1:0] s;
      logic signed [DIM_W+1:0] q;
      logic signed [DIM_W+1:0] top_s;
      p     = $signed({2'b00, pos});
      oe    = (DIM_W + 2)'(ofs);
      s     = p + oe;
      top_s = $signed({2'b00, lim}) - POS_ONE;
      if (s > top_s) q = p - oe;
      else if (s < 0) q = -s;
      else q = s;
      if (q < 0) q = '0;
      if (q > top_s) q = top_s;
      return DELTA_W'(q - p);
   endfunction

   function automatic logic tap_inside(
      input logic [DIM_W-1:0]          pos,
      input logic signed [DELTA_W-1:0] ofs,
      input logic [DIM_W-1:0]          lim
   );
      logic signed [DIM_W+1:0] s;
      s = $signed({2'b00, pos}) + (DIM_W + 2)'(ofs);
      return (s >= 0) && (s <= $signed({2'b00, lim}) - POS_ONE);
   endfunction

   // Drops the Q0.32 fraction and saturates at the channel maximum.
   function automatic logic [CH_W-1:0] sat_high(input logic [ACC_W-1:0] acc);
      logic [ACC_W-WGT_W-1:0] hi;
      hi = acc[ACC_W-1:WGT_W];
      return (|hi[ACC_W-WGT_W-1:CH_W]) ? '1 : hi[CH_W-1:0];
   endfunction

endpackage

>>> rtl/core/gwf_ram.sv
module gwf_ram #(
   parameter int  WIDTH = 24,
   parameter int  DEPTH = 3072,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/gwf_mac.sv
module gwf_mac (
   input  logic                                     clock,
   input  logic                                     reset,
   input  gwf_pkg::mac_ctl_type                     ctl,
   input  logic [gwf_pkg::PIX_W-1:0]                pix,
   output logic [2:0][gwf_pkg::ACC_W-1:0]           acc,
   output logic [gwf_pkg::WSUM_W-1:0]               wsum
);

   logic                                  s1_vld_ff;
   logic [gwf_pkg::WGT_W-1:0]             w_ff;
   logic                                  s2_vld_ff;
   logic [2:0][gwf_pkg::PROD_W-1:0]       prod_ff;
   logic [gwf_pkg::WGT_W-1:0]             wq_ff;
   logic [2:0][gwf_pkg::ACC_W-1:0]        acc_ff;
   logic [gwf_pkg::WSUM_W-1:0]            wsum_ff;

   // Stage one forms the tap weight while the store read is in flight.
   // Stage two scales the three channels; stage three accumulates.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= ctl.issue;
         s2_vld_ff <= s1_vld_ff;
      end
      w_ff  <= {{gwf_pkg::TAP_W{1'b0}}, ctl.vtap} * {{gwf_pkg::TAP_W{1'b0}}, ctl.htap};
      wq_ff <= w_ff;
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= {{gwf_pkg::CH_W{1'b0}}, w_ff}
                     * {{gwf_pkg::WGT_W{1'b0}}, pix[k*gwf_pkg::CH_W +: gwf_pkg::CH_W]};
      end
      if (ctl.clear) begin
         acc_ff  <= '0;
         wsum_ff <= '0;
      end else if (s2_vld_ff) begin
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= acc_ff[k] + gwf_pkg::ACC_W'(prod_ff[k]);
         end
         wsum_ff <= wsum_ff + gwf_pkg::WSUM_W'(wq_ff);
      end
   end

   assign acc  = acc_ff;
   assign wsum = wsum_ff;

endmodule

>>> rtl/core/gwf_div.sv
module gwf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [2:0][gwf_pkg::ACC_W-1:0]    dividend,
   input  logic [gwf_pkg::WSUM_W-1:0]        divisor,
   output logic                              done,
   output logic [2:0][gwf_pkg::CH_W-1:0]     quotient
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [gwf_pkg::STEP_W-1:0]          step_ff;
   logic [2:0][gwf_pkg::ACC_W-1:0]      rem_ff;
   logic [gwf_pkg::WSUM_W-1:0]          den_ff;
   logic [2:0][gwf_pkg::CH_W-1:0]       quo_ff;
   logic [2:0]                          sat_ff;
   logic                                zero_ff;
   logic [gwf_pkg::BIT_W-1:0]           bit_idx;
   logic [gwf_pkg::ACC_W-1:0]           den_sh;

   assign bit_idx = gwf_pkg::BIT_W'(step_ff - 1'b1);
   assign den_sh  = {{gwf_pkg::CH_W{1'b0}}, den_ff} << bit_idx;

   // Restoring division, one quotient bit per cycle for all three channels.
   // A dividend at or above 256 times the divisor saturates up front.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= gwf_pkg::STEP_W'(gwf_pkg::CH_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == gwf_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff  <= dividend;
         den_ff  <= divisor;
         quo_ff  <= '0;
         zero_ff <= (divisor == '0);
         for (int k = 0; k < 3; k++) begin
            sat_ff[k] <= (dividend[k] >= {divisor, {gwf_pkg::CH_W{1'b0}}});
         end
      end else if (busy_ff) begin
         for (int k = 0; k < 3; k++) begin
            if (rem_ff[k] >= den_sh) begin
               rem_ff[k]          <= rem_ff[k] - den_sh;
               quo_ff[k][bit_idx] <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (zero_ff) quotient[k] = '0;
         else if (sat_ff[k]) quotient[k] = '1;
         else quotient[k] = quo_ff[k];
      end
   end

   assign done = done_ff;

endmodule

>>> rtl/core/gaussian_rgb_window_filter_unit.sv
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_op, req_chan0..2
// rsp       out        rsp_valid, rsp_ready, rsp_res0..2, rsp_frame_end
// csr       in         csr_we, csr_index, csr_wdata (write only)
//
// One transaction at a time. One with no output pixel runs only the store and check
// states; one with an output pixel also walks the (2*RADIUS+1)^2 taps (a line store
// read per in-frame tap, every tap when mirroring) and the divider when renormalized.
// Reset is synchronous and clears counters and control; the store needs no clearing.
// A waiting result sits in the output register while the next transaction runs;
// only loading a new result stalls until that register is free.
module gaussian_rgb_window_filter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [gwf_pkg::CH_W-1:0]         req_chan0,
   input  logic [gwf_pkg::CH_W-1:0]         req_chan1,
   input  logic [gwf_pkg::CH_W-1:0]         req_chan2,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gwf_pkg::CH_W-1:0]         rsp_res0,
   output logic [gwf_pkg::CH_W-1:0]         rsp_res1,
   output logic [gwf_pkg::CH_W-1:0]         rsp_res2,
   output logic                             rsp_frame_end,
   input  logic                             csr_we,
   input  logic [gwf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gwf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   gwf_pkg::state_type                  state_ff, state_in;

   logic [gwf_pkg::MODE_W-1:0]          mode_ff;
   logic [gwf_pkg::DIM_W-1:0]           width_reg_ff, height_reg_ff;
   logic [gwf_pkg::CSR_DATA_W-1:0]      vw_ff, hw_ff;
   logic [gwf_pkg::DIM_W-1:0]           w_cur, h_cur;

   logic                                op_ff;
   logic [gwf_pkg::PIX_W-1:0]           pix_ff;

   logic [gwf_pkg::DIM_W-1:0]           in_row_ff, in_col_ff, out_row_ff, out_col_ff;
   logic [gwf_pkg::ADDR_W-1:0]          in_ptr_ff, out_ptr_ff;
   logic [1:0]                          pend_ff;

   logic [gwf_pkg::TIDX_W-1:0]          ta_ff, tb_ff;
   logic [gwf_pkg::FLUSH_W-1:0]         flush_ff;
   logic                                t0_vld_ff;
   logic signed [gwf_pkg::DELTA_W-1:0]  drow_ff, dcol_ff;
   logic [gwf_pkg::DIST_W-1:0]          da_ff, db_ff;

   logic [2:0][gwf_pkg::CH_W-1:0]       result_ff;
   logic                                rsp_valid_ff;
   logic [2:0][gwf_pkg::CH_W-1:0]       rsp_res_ff;
   logic                                rsp_frame_end_ff;

   logic                                accept, store_we, mac_clear, div_start, out_load;
   logic                                last_tap, ready_now, mirror;

   logic [gwf_pkg::DIM_W:0]             in_col_inc, in_row_inc, out_col_inc, out_row_inc;
   logic [gwf_pkg::DIM_W:0]             w_top, h_top, nr, nc;

   logic signed [gwf_pkg::DELTA_W-1:0]  ofs_a, ofs_b, drow_c, dcol_c, abs_a, abs_b;
   logic                                tap_in;

   logic signed [gwf_pkg::SUM_W-1:0]    ofs_row, addr_sum;
   logic [gwf_pkg::ADDR_W-1:0]          rd_addr;
   logic [gwf_pkg::PIX_W-1:0]           rd_data;

   gwf_pkg::mac_ctl_type                mac_ctl;
   logic [2:0][gwf_pkg::ACC_W-1:0]      acc;
   logic [gwf_pkg::WSUM_W-1:0]          wsum;
   logic                                div_done;
   logic [2:0][gwf_pkg::CH_W-1:0]       div_quo;

   // Frame size as used everywhere: clamped to the supported range.
   always_comb begin
      if (width_reg_ff == '0) w_cur = gwf_pkg::DIM_W'(1);
      else if (width_reg_ff > gwf_pkg::DIM_W'(gwf_pkg::W_LIM))
         w_cur = gwf_pkg::DIM_W'(gwf_pkg::W_LIM);
      else w_cur = width_reg_ff;
      if (height_reg_ff == '0) h_cur = gwf_pkg::DIM_W'(1);
      else if (height_reg_ff > gwf_pkg::DIM_W'(gwf_pkg::H_LIM))
         h_cur = gwf_pkg::DIM_W'(gwf_pkg::H_LIM);
      else h_cur = height_reg_ff;
   end

   assign w_top       = {1'b0, w_cur} - 1'b1;
   assign h_top       = {1'b0, h_cur} - 1'b1;
   assign in_col_inc  = {1'b0, in_col_ff} + 1'b1;
   assign in_row_inc  = {1'b0, in_row_ff} + 1'b1;
   assign out_col_inc = {1'b0, out_col_ff} + 1'b1;
   assign out_row_inc = {1'b0, out_row_ff} + 1'b1;

   // An output pixel is ready once the input has passed the bottom-right corner
   // of its in-frame neighborhood, or once its whole frame is in.
   always_comb begin
      nr = {1'b0, out_row_ff} + (gwf_pkg::DIM_W + 1)'(gwf_pkg::RADIUS);
      nc = {1'b0, out_col_ff} + (gwf_pkg::DIM_W + 1)'(gwf_pkg::RADIUS);
      if (nr > h_top) nr = h_top;
      if (nc > w_top) nc = w_top;
      ready_now = (pend_ff != 2'd0) || (nr < {1'b0, in_row_ff})
               || ((nr == {1'b0, in_row_ff}) && (nc < {1'b0, in_col_ff}));
   end

   // Tap geometry for the current window position.
   assign mirror   = (mode_ff == gwf_pkg::MODE_MIRROR);
   assign ofs_a    = $signed({1'b0, ta_ff}) - $signed(gwf_pkg::DELTA_W'(gwf_pkg::RADIUS));
   assign ofs_b    = $signed({1'b0, tb_ff}) - $signed(gwf_pkg::DELTA_W'(gwf_pkg::RADIUS));
   assign abs_a    = ofs_a[gwf_pkg::DELTA_W-1] ? -ofs_a : ofs_a;
   assign abs_b    = ofs_b[gwf_pkg::DELTA_W-1] ? -ofs_b : ofs_b;
   assign drow_c   = mirror ? gwf_pkg::tap_delta(out_row_ff, ofs_a, h_cur) : ofs_a;
   assign dcol_c   = mirror ? gwf_pkg::tap_delta(out_col_ff, ofs_b, w_cur) : ofs_b;
   assign tap_in   = mirror || (gwf_pkg::tap_inside(out_row_ff, ofs_a, h_cur)
                             && gwf_pkg::tap_inside(out_col_ff, ofs_b, w_cur));
   assign last_tap = (ta_ff == gwf_pkg::TIDX_W'(gwf_pkg::WIN - 1))
                  && (tb_ff == gwf_pkg::TIDX_W'(gwf_pkg::WIN - 1));

   // Store address of a tap: the center pointer plus the row and column offset,
   // wrapped once around the circular store.
   always_comb begin
      ofs_row  = gwf_pkg::SUM_W'(drow_ff * $signed({1'b0, w_cur}));
      addr_sum = $signed({{(gwf_pkg::SUM_W - gwf_pkg::ADDR_W){1'b0}}, out_ptr_ff})
               + ofs_row + gwf_pkg::SUM_W'(dcol_ff);
      if (addr_sum < 0) rd_addr = gwf_pkg::ADDR_W'(addr_sum + gwf_pkg::DEPTH_S);
      else if (addr_sum >= gwf_pkg::DEPTH_S) rd_addr = gwf_pkg::ADDR_W'(addr_sum - gwf_pkg::DEPTH_S);
      else rd_addr = gwf_pkg::ADDR_W'(addr_sum);
   end

   always_comb begin
      mac_ctl.clear = mac_clear;
      mac_ctl.issue = t0_vld_ff;
      mac_ctl.vtap  = vw_ff[da_ff * gwf_pkg::TAP_W +: gwf_pkg::TAP_W];
      mac_ctl.htap  = hw_ff[db_ff * gwf_pkg::TAP_W +: gwf_pkg::TAP_W];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gwf_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      store_we  = 1'b0;
      mac_clear = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         gwf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = gwf_pkg::ST_STORE;
         end
         gwf_pkg::ST_STORE: begin
            store_we = (op_ff == gwf_pkg::OP_PIXEL);
            state_in = gwf_pkg::ST_CHECK;
         end
         gwf_pkg::ST_CHECK: begin
            if (ready_now) begin
               mac_clear = 1'b1;
               state_in  = gwf_pkg::ST_TAPS;
            end else begin
               state_in = gwf_pkg::ST_IDLE;
            end
         end
         gwf_pkg::ST_TAPS: begin
            if (last_tap) state_in = gwf_pkg::ST_FLUSH;
         end
         gwf_pkg::ST_FLUSH: begin
            if (flush_ff == gwf_pkg::FLUSH_W'(gwf_pkg::FLUSH_CYCLES - 1))
               state_in = gwf_pkg::ST_NORM;
         end
         gwf_pkg::ST_NORM: begin
            if (mode_ff == gwf_pkg::MODE_ADJUST) begin
               div_start = 1'b1;
               state_in  = gwf_pkg::ST_DIV;
            end else begin
               state_in = gwf_pkg::ST_OUT;
            end
         end
         gwf_pkg::ST_DIV: begin
            if (div_done) state_in = gwf_pkg::ST_OUT;
         end
         gwf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = gwf_pkg::ST_IDLE;
            end
         end
         default: state_in = gwf_pkg::ST_IDLE;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= gwf_pkg::MODE_ZERO;
         width_reg_ff  <= gwf_pkg::DIM_RESET;
         height_reg_ff <= gwf_pkg::DIM_RESET;
         vw_ff         <= gwf_pkg::WEIGHT_RESET;
         hw_ff         <= gwf_pkg::WEIGHT_RESET;
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         in_ptr_ff     <= '0;
         out_ptr_ff    <= '0;
         pend_ff       <= '0;
         ta_ff         <= '0;
         tb_ff         <= '0;
         flush_ff      <= '0;
         t0_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               gwf_pkg::CSR_MODE:     mode_ff       <= csr_wdata[gwf_pkg::MODE_W-1:0];
               gwf_pkg::CSR_WIDTH:    width_reg_ff  <= csr_wdata[gwf_pkg::DIM_W-1:0];
               gwf_pkg::CSR_HEIGHT:   height_reg_ff <= csr_wdata[gwf_pkg::DIM_W-1:0];
               gwf_pkg::CSR_VWEIGHTS: vw_ff         <= csr_wdata;
               gwf_pkg::CSR_HWEIGHTS: hw_ff         <= csr_wdata;
               default: ;
            endcase
         end

         if (store_we) begin
            in_ptr_ff <= (in_ptr_ff == gwf_pkg::ADDR_W'(gwf_pkg::STORE_DEPTH - 1))
                       ? '0 : in_ptr_ff + 1'b1;
            if (in_col_inc >= {1'b0, w_cur}) begin
               in_col_ff <= '0;
               if (in_row_inc >= {1'b0, h_cur}) begin
                  in_row_ff <= '0;
                  if (pend_ff != 2'd2) pend_ff <= pend_ff + 1'b1;
               end else begin
                  in_row_ff <= gwf_pkg::DIM_W'(in_row_inc);
               end
            end else begin
               in_col_ff <= gwf_pkg::DIM_W'(in_col_inc);
            end
         end

         if (state_ff == gwf_pkg::ST_CHECK) begin
            ta_ff <= '0;
            tb_ff <= '0;
         end else if (state_ff == gwf_pkg::ST_TAPS) begin
            if (tb_ff == gwf_pkg::TIDX_W'(gwf_pkg::WIN - 1)) begin
               tb_ff <= '0;
               ta_ff <= ta_ff + 1'b1;
            end else begin
               tb_ff <= tb_ff + 1'b1;
            end
         end

         t0_vld_ff <= (state_ff == gwf_pkg::ST_TAPS) && tap_in;

         if (state_ff == gwf_pkg::ST_TAPS) flush_ff <= '0;
         else if (state_ff == gwf_pkg::ST_FLUSH) flush_ff <= flush_ff + 1'b1;

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            out_ptr_ff   <= (out_ptr_ff == gwf_pkg::ADDR_W'(gwf_pkg::STORE_DEPTH - 1))
                          ? '0 : out_ptr_ff + 1'b1;
            if (out_col_inc >= {1'b0, w_cur}) begin
               out_col_ff <= '0;
               if (out_row_inc >= {1'b0, h_cur}) begin
                  out_row_ff <= '0;
                  if (pend_ff != 2'd0) pend_ff <= pend_ff - 1'b1;
               end else begin
                  out_row_ff <= gwf_pkg::DIM_W'(out_row_inc);
               end
            end else begin
               out_col_ff <= gwf_pkg::DIM_W'(out_col_inc);
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Payload registers.
      if (accept) begin
         op_ff  <= req_op;
         pix_ff <= {req_chan2, req_chan1, req_chan0};
      end
      drow_ff <= drow_c;
      dcol_ff <= dcol_c;
      da_ff   <= gwf_pkg::DIST_W'(abs_a);
      db_ff   <= gwf_pkg::DIST_W'(abs_b);
      if (state_ff == gwf_pkg::ST_NORM) begin
         for (int k = 0; k < 3; k++) begin
            if ((mode_ff == gwf_pkg::MODE_ZERO) || (mode_ff == gwf_pkg::MODE_MIRROR))
               result_ff[k] <= gwf_pkg::sat_high(acc[k]);
            else result_ff[k] <= '0;
         end
      end else if ((state_ff == gwf_pkg::ST_DIV) && div_done) begin
         result_ff <= div_quo;
      end
      if (out_load) begin
         rsp_res_ff       <= result_ff;
         rsp_frame_end_ff <= ({1'b0, out_row_ff} >= h_top) && ({1'b0, out_col_ff} >= w_top);
      end
   end

   gwf_ram #(
      .WIDTH (gwf_pkg::PIX_W),
      .DEPTH (gwf_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (store_we),
      .waddr (in_ptr_ff),
      .wdata (pix_ff),
      .re    (t0_vld_ff),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   gwf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .pix   (rd_data),
      .acc   (acc),
      .wsum  (wsum)
   );

   gwf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc),
      .divisor  (wsum),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res0      = rsp_res_ff[0];
   assign rsp_res1      = rsp_res_ff[1];
   assign rsp_res2      = rsp_res_ff[2];
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

>>> rtl/core/gwf_checker.sv
`include "gaussian_rgb_window_filter_unit_defines.svh"

module gwf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [gwf_pkg::CH_W-1:0]         rsp_res0,
   input logic [gwf_pkg::CH_W-1:0]         rsp_res1,
   input logic [gwf_pkg::CH_W-1:0]         rsp_res2,
   input logic                             rsp_frame_end
);

   logic [3*gwf_pkg::CH_W:0] rsp_payload;

   assign rsp_payload = {rsp_frame_end, rsp_res2, rsp_res1, rsp_res0};

   `GWF_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `GWF_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload))
   // After a transaction is taken, the block is not ready in the next cycle.
   `GWF_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // A new result is only presented right after the block was busy.
   `GWF_ASSERT_IMP(a_rsp_after_work, $rose(rsp_valid), $past(!req_ready))

endmodule

bind gaussian_rgb_window_filter_unit gwf_checker u_gwf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_res0      (rsp_res0),
   .rsp_res1      (rsp_res1),
   .rsp_res2      (rsp_res2),
   .rsp_frame_end (rsp_frame_end)
);
